/* hw/rtl/rsp_pkg.sv */
// Shared types and constants for the rise/set/peak detector.
package rsp_pkg;

  // Field widths
  localparam int TIME_W          = 30;
  localparam int ANGLE_W         = 24;
  localparam int ANGLE_FRAC_BITS = 16;

  // Interpolation datapath widths
  localparam int DEN_W  = ANGLE_W + 1;
  localparam int PROD_W = TIME_W + ANGLE_W;
  localparam int CNT_W  = $clog2(TIME_W);

  // Samples at or below -90 degrees are treated as absent
  localparam logic signed [ANGLE_W-1:0] ABSENT_LIMIT =
    ANGLE_W'(-90 * (1 << ANGLE_FRAC_BITS));

  // Queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Crossing kind of a request
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_RISE = 2'd1;
  localparam kind_t KIND_SET  = 2'd2;

  // Classified request from the front end to the back end
  typedef struct packed {
    kind_t               kind;
    logic                dir_neg;
    logic [TIME_W-1:0]   t_prev;
    logic [TIME_W-1:0]   t_mag;
    logic [ANGLE_W-1:0]  a_prev_mag;
    logic [DEN_W-1:0]    den;
    logic                peak_event;
    logic [TIME_W-1:0]   peak_at;
    logic                all_found;
  } job_t;

endpackage

/* hw/rtl/rise_set_peak_detector.sv */
// Top level of the rise/set/peak detector.
// Each request is classified by the front end, queued, and finished by the back end;
// a crossing adds 1 multiply and 30 divide steps in the back end before the result.
// Samples are taken while the back end is busy until the queue is full (in_stall);
// one request at a time in the back end; radix-2 divider, one quotient bit per cycle.
// Reset (rst_n low, synchronous): window, found flags, stored times and queue cleared.
module rise_set_peak_detector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rsp_pkg::TIME_W-1:0]         in_sample_time,
  input  logic signed [rsp_pkg::ANGLE_W-1:0] in_sample_altitude,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_rise_event,
  output logic [rsp_pkg::TIME_W-1:0]         out_rise_at,
  output logic                               out_set_event,
  output logic [rsp_pkg::TIME_W-1:0]         out_set_at,
  output logic                               out_peak_event,
  output logic [rsp_pkg::TIME_W-1:0]         out_peak_at,
  output logic                               out_all_found
);

  rsp_pkg::job_t front_job;
  rsp_pkg::job_t q_job;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  rsp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .sample_time     (in_sample_time),
    .sample_altitude (in_sample_altitude),
    .job             (front_job)
  );

  rsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_job   (q_job),
    .not_empty (q_valid)
  );

  rsp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_job          (q_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rise_event (out_rise_event),
    .out_rise_at    (out_rise_at),
    .out_set_event  (out_set_event),
    .out_set_at     (out_set_at),
    .out_peak_event (out_peak_event),
    .out_peak_at    (out_peak_at),
    .out_all_found  (out_all_found)
  );

endmodule

/* hw/rtl/rsp_front.sv */
// Front end: sample window, crossing/peak classification, found flags.
module rsp_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  logic [rsp_pkg::TIME_W-1:0]         sample_time,
  input  logic signed [rsp_pkg::ANGLE_W-1:0] sample_altitude,
  output rsp_pkg::job_t                      job
);

  logic [rsp_pkg::TIME_W-1:0]         time_r [3];
  logic signed [rsp_pkg::ANGLE_W-1:0] ang_r  [3];
  logic [2:0]                         pres_r;
  logic [2:0]                         found_r;
  logic [2:0]                         found_nxt;
  logic [rsp_pkg::TIME_W-1:0]         peak_r;
  logic [rsp_pkg::TIME_W-1:0]         peak_nxt;

  logic                               p3;
  logic                               active;
  logic                               rise_hit;
  logic                               set_hit;
  logic                               peak_hit;
  logic                               dir_neg;
  logic [rsp_pkg::ANGLE_W-1:0]        aap;
  logic [rsp_pkg::ANGLE_W-1:0]        aac;
  logic [rsp_pkg::TIME_W:0]           t_sum;

  // Classify the incoming sample against the window
  always_comb begin
    p3       = sample_altitude > rsp_pkg::ABSENT_LIMIT;
    active   = found_r != 3'b111;
    rise_hit = pres_r[2] && p3 && (ang_r[2] < 0) && (sample_altitude > 0);
    set_hit  = pres_r[2] && p3 && (ang_r[2] > 0) && (sample_altitude < 0);
    peak_hit = (&pres_r) && p3 && (ang_r[0] < ang_r[1]) &&
               (ang_r[2] > sample_altitude) && !found_r[2];

    // magnitudes for the interpolation
    dir_neg = sample_time < time_r[2];
    aap = ang_r[2][rsp_pkg::ANGLE_W-1] ? rsp_pkg::ANGLE_W'(~ang_r[2] + 1'b1)
                                       : rsp_pkg::ANGLE_W'(ang_r[2]);
    aac = sample_altitude[rsp_pkg::ANGLE_W-1]
          ? rsp_pkg::ANGLE_W'(~sample_altitude + 1'b1)
          : rsp_pkg::ANGLE_W'(sample_altitude);
    t_sum = {1'b0, time_r[1]} + {1'b0, time_r[2]};

    found_nxt = found_r;
    peak_nxt  = peak_r;
    if (active) begin
      found_nxt = found_r | {peak_hit, set_hit, rise_hit};
      if (peak_hit) begin
        peak_nxt = t_sum[rsp_pkg::TIME_W:1];
      end
    end

    job.kind = rsp_pkg::KIND_NONE;
    if (active && rise_hit) begin
      job.kind = rsp_pkg::KIND_RISE;
    end else if (active && set_hit) begin
      job.kind = rsp_pkg::KIND_SET;
    end
    job.dir_neg    = dir_neg;
    job.t_prev     = time_r[2];
    job.t_mag      = dir_neg ? (time_r[2] - sample_time) : (sample_time - time_r[2]);
    job.a_prev_mag = aap;
    job.den        = {1'b0, aap} + {1'b0, aac};
    job.peak_event = active && peak_hit;
    job.peak_at    = peak_nxt;
    job.all_found  = found_nxt == 3'b111;
  end

  // Window shift and found state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        time_r[i] <= '0;
        ang_r[i]  <= '0;
      end
      pres_r  <= '0;
      found_r <= '0;
      peak_r  <= '0;
    end else if (push && active) begin
      time_r[0] <= time_r[1];
      time_r[1] <= time_r[2];
      time_r[2] <= sample_time;
      ang_r[0]  <= ang_r[1];
      ang_r[1]  <= ang_r[2];
      ang_r[2]  <= sample_altitude;
      pres_r    <= {p3, pres_r[2:1]};
      found_r   <= found_nxt;
      peak_r    <= peak_nxt;
    end
  end

endmodule

/* hw/rtl/rsp_queue.sv */
// Two-entry request queue between front end and back end.
module rsp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rsp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output rsp_pkg::job_t pop_job,
  output logic          not_empty
);

  rsp_pkg::job_t                 mem_r [rsp_pkg::QDEPTH];
  logic [rsp_pkg::QPTR_W-1:0]    wr_r;
  logic [rsp_pkg::QPTR_W-1:0]    rd_r;
  logic [rsp_pkg::QCNT_W-1:0]    cnt_r;

  assign full      = cnt_r == rsp_pkg::QCNT_W'(rsp_pkg::QDEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_job   = mem_r[rd_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + rsp_pkg::QCNT_W'(push) - rsp_pkg::QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("request queue underflow");

endmodule

/* hw/rtl/rsp_back.sv */
// Back end: interpolation (multiply + radix-2 divide), stored times, result register.
module rsp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  rsp_pkg::job_t              q_job,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_rise_event,
  output logic [rsp_pkg::TIME_W-1:0] out_rise_at,
  output logic                       out_set_event,
  output logic [rsp_pkg::TIME_W-1:0] out_set_at,
  output logic                       out_peak_event,
  output logic [rsp_pkg::TIME_W-1:0] out_peak_at,
  output logic                       out_all_found
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  rsp_pkg::job_t               job_r;
  logic [rsp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [rsp_pkg::DEN_W-1:0]   rem_r, rem_nxt;
  logic [rsp_pkg::TIME_W-1:0]  dvd_r, dvd_nxt;
  logic [rsp_pkg::TIME_W-1:0]  rise_r, rise_nxt;
  logic [rsp_pkg::TIME_W-1:0]  set_r, set_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        load_out;

  logic [rsp_pkg::PROD_W-1:0]  prod;
  logic [rsp_pkg::DEN_W-1:0]   trial;
  logic                        ge;
  logic [rsp_pkg::TIME_W-1:0]  new_t;

  logic                        o_rise_ev_r, o_set_ev_r, o_peak_ev_r, o_all_r;
  logic [rsp_pkg::TIME_W-1:0]  o_rise_at_r, o_set_at_r, o_peak_at_r;

  // Datapath: product, one divide step, final offset
  always_comb begin
    prod  = rsp_pkg::PROD_W'(job_r.t_mag) * rsp_pkg::PROD_W'(job_r.a_prev_mag);
    trial = {rem_r[rsp_pkg::DEN_W-2:0], dvd_r[rsp_pkg::TIME_W-1]};
    ge    = trial >= job_r.den;
    new_t = job_r.dir_neg ? (job_r.t_prev - dvd_r) : (job_r.t_prev + dvd_r);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    rise_nxt      = rise_r;
    set_nxt       = set_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    load_out      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = (q_job.kind == rsp_pkg::KIND_NONE) ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        // quotient fits TIME_W bits, so the high part is below the divisor
        rem_nxt   = rsp_pkg::DEN_W'(prod[rsp_pkg::PROD_W-1:rsp_pkg::TIME_W]);
        dvd_nxt   = prod[rsp_pkg::TIME_W-1:0];
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? (trial - job_r.den) : trial;
        dvd_nxt = {dvd_r[rsp_pkg::TIME_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == rsp_pkg::CNT_W'(rsp_pkg::TIME_W - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (job_r.kind == rsp_pkg::KIND_RISE) begin
            rise_nxt = new_t;
          end
          if (job_r.kind == rsp_pkg::KIND_SET) begin
            set_nxt = new_t;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and stored times
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rise_r      <= '0;
      set_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rise_r      <= rise_nxt;
      set_r       <= set_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_rise_ev_r <= job_r.kind == rsp_pkg::KIND_RISE;
      o_set_ev_r  <= job_r.kind == rsp_pkg::KIND_SET;
      o_peak_ev_r <= job_r.peak_event;
      o_all_r     <= job_r.all_found;
      o_rise_at_r <= rise_nxt;
      o_set_at_r  <= set_nxt;
      o_peak_at_r <= job_r.peak_at;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rise_event = o_rise_ev_r;
  assign out_rise_at    = o_rise_at_r;
  assign out_set_event  = o_set_ev_r;
  assign out_set_at     = o_set_at_r;
  assign out_peak_event = o_peak_ev_r;
  assign out_peak_at    = o_peak_at_r;
  assign out_all_found  = o_all_r;

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= rsp_pkg::CNT_W'(rsp_pkg::TIME_W - 1)))
    else $error("divide step count out of range");

  a_one_crossing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(o_rise_ev_r && o_set_ev_r))
    else $error("rise and set reported together");

endmodule
